>>> src/bnpt_pkg.sv
// bnpt_pkg: shared types and constants for the bus node poll table
// command codes, word structs, sequencer states and slot sizing
// no dependencies
`default_nettype none

package bnpt_pkg;

	// slot count and derived widths
	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SS_W  = $clog2(SLOTS + 1);
	localparam int RES_W = 5;

	// entry and config reset values
	localparam logic [7:0] CD_RESET = 8'hFF;
	localparam logic [7:0] FC_RESET = 8'h00;
	localparam logic [7:0] MAX_ERR_RESET = 8'd3;

	// command codes
	localparam logic [2:0] CMD_FIND_FREE  = 3'd0;
	localparam logic [2:0] CMD_ADD        = 3'd1;
	localparam logic [2:0] CMD_CLEAR      = 3'd2;
	localparam logic [2:0] CMD_PING_FAIL  = 3'd3;
	localparam logic [2:0] CMD_SET_PERIOD = 3'd4;
	localparam logic [2:0] CMD_TICK       = 3'd5;
	localparam logic [2:0] CMD_NEXT_PING  = 3'd6;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] node_addr;
		logic [7:0] period;
	} in_word_t;

	typedef struct packed {
		logic [RES_W-1:0] result_addr;
		logic             ok;
		logic             bad_addr;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RMW,
		ST_TICK,
		ST_SCAN,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

>>> src/bus_node_poll_table.sv
// bus_node_poll_table: node slot table with countdown polling
// one command word in, one result word out; slot state in sync memory, registered read
// depends on bnpt_pkg
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    bnpt_pkg::in_word_t
// out       output     out_valid / out_ready  bnpt_pkg::out_word_t
// cfg       input      cfg_we                 cfg_wdata (max_ping_errors)
//
// find_free, bad address, unknown, idle next_ping: accept, then the result stage.
// add, clear, ping fail, set_period: memory read, modify, write (add: used bit only).
// tick: every memory entry walked, one per cycle.
// pending next_ping: walks entries, stops at the first zero countdown.
// reset clears the entry valid bits; unwritten entries read as countdown 0xFF, fail 0.
// a stalled output holds its word; the next command is taken and waits at its end.
`default_nettype none

module bus_node_poll_table (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire bnpt_pkg::in_word_t   in_data,
	output logic                      out_valid,
	input  wire                       out_ready,
	output bnpt_pkg::out_word_t       out_data,
	input  wire                       cfg_we,
	input  wire  [7:0]                cfg_wdata
);

	typedef struct packed {
		logic [7:0] cd;
		logic [7:0] fc;
	} entry_t;

	// slot memory and its entry valid bits
	entry_t mem [bnpt_pkg::SLOTS];
	logic [bnpt_pkg::SLOTS-1:0] vld_q;
	logic [bnpt_pkg::SLOTS-1:0] used_q, used_d;

	entry_t rd_data_q;
	logic   rd_vld_q;
	logic   rd_en;
	logic [bnpt_pkg::IDX_W-1:0] rd_idx;
	logic   wr_en;
	logic [bnpt_pkg::IDX_W-1:0] wr_idx;
	entry_t wr_data;

	bnpt_pkg::state_t state_q, state_d;
	logic [7:0] max_err_q;
	logic [2:0] cmd_q, cmd_d;
	logic [7:0] per_q, per_d;
	logic [bnpt_pkg::IDX_W-1:0] cur_idx_q, cur_idx_d;
	logic [bnpt_pkg::IDX_W-1:0] k_q, k_d;
	logic [bnpt_pkg::SS_W-1:0] res_q, res_d;
	logic ok_q, ok_d, bad_q, bad_d;
	logic pending_q, pending_d;
	logic [bnpt_pkg::SS_W-1:0] sstart_q, sstart_d;

	logic out_valid_q;
	bnpt_pkg::out_word_t out_q;
	logic out_load;

	// combinational helpers
	logic accept;
	logic addr_bad;
	logic [bnpt_pkg::IDX_W-1:0] in_idx;
	logic [bnpt_pkg::IDX_W-1:0] scan_start;
	logic [bnpt_pkg::IDX_W-1:0] next_idx;
	logic [bnpt_pkg::SS_W-1:0] first_free;
	logic [7:0] cur_cd, cur_fc, fc_inc;
	logic walk_last;

	assign accept   = in_valid && in_ready;
	assign addr_bad = (in_data.node_addr == 8'd0) ||
		(in_data.node_addr > 8'(bnpt_pkg::SLOTS));
	assign in_idx   = bnpt_pkg::IDX_W'(in_data.node_addr - 8'd1);
	assign scan_start = (sstart_q >= bnpt_pkg::SS_W'(bnpt_pkg::SLOTS)) ? '0 :
		bnpt_pkg::IDX_W'(sstart_q);
	assign next_idx = (cur_idx_q == bnpt_pkg::IDX_W'(bnpt_pkg::SLOTS - 1)) ? '0 :
		cur_idx_q + 1'b1;
	assign walk_last = (k_q == bnpt_pkg::IDX_W'(bnpt_pkg::SLOTS - 1));

	// entry fields as read, with unwritten entries at their reset values
	assign cur_cd = rd_vld_q ? rd_data_q.cd : bnpt_pkg::CD_RESET;
	assign cur_fc = rd_vld_q ? rd_data_q.fc : bnpt_pkg::FC_RESET;
	assign fc_inc = (cur_fc == 8'hFF) ? cur_fc : cur_fc + 8'd1;

	// lowest free address over the used bits
	always_comb begin
		first_free = '0;
		for (int i = bnpt_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				first_free = bnpt_pkg::SS_W'(i + 1);
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bnpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state, memory control and next register values
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		rd_idx    = '0;
		wr_en     = 1'b0;
		wr_idx    = cur_idx_q;
		wr_data   = '{cd: cur_cd, fc: cur_fc};
		used_d    = used_q;
		cmd_d     = cmd_q;
		per_d     = per_q;
		cur_idx_d = cur_idx_q;
		k_d       = k_q;
		res_d     = res_q;
		ok_d      = ok_q;
		bad_d     = bad_q;
		pending_d = pending_q;
		sstart_d  = sstart_q;
		out_load  = 1'b0;
		case (state_q)
			bnpt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					cmd_d = in_data.cmd;
					per_d = in_data.period;
					res_d = '0;
					ok_d  = 1'b1;
					bad_d = 1'b0;
					state_d = bnpt_pkg::ST_FIN;
					case (in_data.cmd)
						bnpt_pkg::CMD_ADD, bnpt_pkg::CMD_CLEAR,
						bnpt_pkg::CMD_PING_FAIL, bnpt_pkg::CMD_SET_PERIOD: begin
							if (addr_bad) begin
								ok_d  = 1'b0;
								bad_d = 1'b1;
							end else begin
								rd_en     = 1'b1;
								rd_idx    = in_idx;
								cur_idx_d = in_idx;
								state_d   = bnpt_pkg::ST_RMW;
							end
						end
						bnpt_pkg::CMD_FIND_FREE: begin
							res_d = first_free;
						end
						bnpt_pkg::CMD_TICK: begin
							rd_en     = 1'b1;
							rd_idx    = '0;
							cur_idx_d = '0;
							k_d       = '0;
							state_d   = bnpt_pkg::ST_TICK;
						end
						bnpt_pkg::CMD_NEXT_PING: begin
							if (pending_q) begin
								rd_en     = 1'b1;
								rd_idx    = scan_start;
								cur_idx_d = scan_start;
								k_d       = '0;
								state_d   = bnpt_pkg::ST_SCAN;
							end
						end
						default: begin
							ok_d = 1'b0;
						end
					endcase
				end
			end
			bnpt_pkg::ST_RMW: begin
				state_d = bnpt_pkg::ST_FIN;
				case (cmd_q)
					bnpt_pkg::CMD_ADD: begin
						ok_d = !used_q[cur_idx_q];
						used_d[cur_idx_q] = 1'b1;
					end
					bnpt_pkg::CMD_CLEAR: begin
						used_d[cur_idx_q] = 1'b0;
						wr_en   = 1'b1;
						wr_data = '{cd: bnpt_pkg::CD_RESET, fc: bnpt_pkg::FC_RESET};
					end
					bnpt_pkg::CMD_PING_FAIL: begin
						wr_en = 1'b1;
						if (fc_inc >= max_err_q) begin
							used_d[cur_idx_q] = 1'b0;
							wr_data = '{cd: bnpt_pkg::CD_RESET, fc: bnpt_pkg::FC_RESET};
						end else begin
							wr_data = '{cd: cur_cd, fc: fc_inc};
						end
					end
					bnpt_pkg::CMD_SET_PERIOD: begin
						if (per_q != 8'd0) begin
							wr_en   = 1'b1;
							wr_data = '{cd: per_q, fc: bnpt_pkg::FC_RESET};
						end else begin
							ok_d = 1'b0;
						end
					end
					default: begin
						ok_d = 1'b0;
					end
				endcase
			end
			bnpt_pkg::ST_TICK: begin
				// decrement live countdowns, one entry a cycle
				if (used_q[cur_idx_q] && cur_cd != 8'd0) begin
					wr_en   = 1'b1;
					wr_data = '{cd: cur_cd - 8'd1, fc: cur_fc};
					if (cur_cd == 8'd1) begin
						pending_d = 1'b1;
					end
				end
				if (walk_last) begin
					state_d = bnpt_pkg::ST_FIN;
				end else begin
					rd_en     = 1'b1;
					rd_idx    = cur_idx_q + 1'b1;
					cur_idx_d = cur_idx_q + 1'b1;
					k_d       = k_q + 1'b1;
				end
			end
			bnpt_pkg::ST_SCAN: begin
				// circular search for a zero countdown
				if (cur_cd == 8'd0) begin
					res_d    = bnpt_pkg::SS_W'(cur_idx_q) + 1'b1;
					sstart_d = bnpt_pkg::SS_W'(cur_idx_q) + 1'b1;
					state_d  = bnpt_pkg::ST_FIN;
				end else if (walk_last) begin
					pending_d = 1'b0;
					state_d   = bnpt_pkg::ST_FIN;
				end else begin
					rd_en     = 1'b1;
					rd_idx    = next_idx;
					cur_idx_d = next_idx;
					k_d       = k_q + 1'b1;
				end
			end
			bnpt_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = bnpt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bnpt_pkg::ST_IDLE;
			end
		endcase
	end

	// slot memory: one read and one write port, registered read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	// entry valid bits, read alongside the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_idx];
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			pending_q   <= 1'b0;
			sstart_q    <= '0;
			max_err_q   <= bnpt_pkg::MAX_ERR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			used_q    <= used_d;
			pending_q <= pending_d;
			sstart_q  <= sstart_d;
			if (cfg_we) begin
				max_err_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command and result registers
	always_ff @(posedge clk) begin
		cmd_q     <= cmd_d;
		per_q     <= per_d;
		cur_idx_q <= cur_idx_d;
		k_q       <= k_d;
		res_q     <= res_d;
		ok_q      <= ok_d;
		bad_q     <= bad_d;
		if (out_load) begin
			out_q.result_addr <= bnpt_pkg::RES_W'(res_q);
			out_q.ok          <= ok_q;
			out_q.bad_addr    <= bad_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> src/bnpt_checker.sv
// bnpt_checker: port-level checks on the bus node poll table
// bound to bus_node_poll_table; depends on bnpt_pkg
`default_nettype none

module bnpt_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      in_valid,
	input wire                      in_ready,
	input wire bnpt_pkg::in_word_t  in_data,
	input wire                      out_valid,
	input wire                      out_ready,
	input wire bnpt_pkg::out_word_t out_data
);

	// an offered command word holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("command word changed while waiting");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// a bad address never reports success
	a_bad_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.bad_addr && out_data.ok))
		else $error("bad address with ok set");

	// a found address comes only from an accepted search
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_addr != '0 |-> out_data.ok && !out_data.bad_addr)
		else $error("address returned without ok");

	// a found address lies within the table
	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_data.result_addr) <= bnpt_pkg::SLOTS)
		else $error("address beyond slot count");

endmodule

bind bus_node_poll_table bnpt_checker u_bnpt_checker (.*);

`default_nettype wire
